@@ design/cmrg_pkg.sv @@
`default_nettype none

package cmrg_pkg;

   // moduli of the two components and the seed range
   localparam logic [30:0] MOD_ONE    = 31'd2147483647;
   localparam logic [30:0] MOD_TWO    = 31'd2145483479;
   localparam logic [30:0] SEED_RANGE = 31'd2145483478;

   // 2^31 mod m, used to fold the bits above bit 30 back into the low word
   localparam logic [20:0] FOLD_ONE = 21'd1;
   localparam logic [20:0] FOLD_TWO = 21'd2000169;

   // recurrence multipliers (the negative ones stored as magnitudes)
   localparam logic [19:0] COEF_ONE_POS = 20'd63308;
   localparam logic [19:0] COEF_ONE_NEG = 20'd183326;
   localparam logic [19:0] COEF_TWO_POS = 20'd86098;
   localparam logic [19:0] COEF_TWO_NEG = 20'd539608;

   // width of the working accumulator: 20-bit coefficient times 31-bit word
   localparam int ACC_W = 51;

   // seed words, in load order
   localparam logic [2:0] WORD_FIRST_OLDEST  = 3'd0;
   localparam logic [2:0] WORD_FIRST_MIDDLE  = 3'd1;
   localparam logic [2:0] WORD_FIRST_NEWEST  = 3'd2;
   localparam logic [2:0] WORD_SECOND_OLDEST = 3'd3;
   localparam logic [2:0] WORD_SECOND_MIDDLE = 3'd4;
   localparam logic [2:0] WORD_SECOND_NEWEST = 3'd5;

   // product terms of one draw, in order of evaluation
   localparam logic [1:0] TERM_ONE_POS = 2'd0;
   localparam logic [1:0] TERM_ONE_NEG = 2'd1;
   localparam logic [1:0] TERM_TWO_POS = 2'd2;
   localparam logic [1:0] TERM_TWO_NEG = 2'd3;

   // the all-ones seed, which a seed load replaces by seed zero
   localparam logic [31:0] SEED_ALL_ONES = 32'hFFFFFFFF;

   typedef logic [30:0] word_type;

   // per-word seeding key
   function automatic word_type seed_key(input logic [2:0] idx);
      word_type key;
      unique case (idx)
         WORD_FIRST_OLDEST:  key = 31'd2039845123;
         WORD_FIRST_MIDDLE:  key = 31'd182401045;
         WORD_FIRST_NEWEST:  key = 31'd1190945568;
         WORD_SECOND_OLDEST: key = 31'd943583831;
         WORD_SECOND_MIDDLE: key = 31'd1345908737;
         WORD_SECOND_NEWEST: key = 31'd723161013;
         default:            key = 31'd0;
      endcase
      return key;
   endfunction

   // ((key xor seed) and 0x7fffffff) mod range, plus one; the value is below twice the range
   function automatic word_type seed_word(input word_type key, input logic [31:0] seed);
      word_type v;
      v = key ^ seed[30:0];
      if (v >= SEED_RANGE) begin
         return v - SEED_RANGE + 31'd1;
      end else begin
         return v + 31'd1;
      end
   endfunction

endpackage

`default_nettype wire

@@ design/combined_mrg_random_generator_unit.sv @@
// channel   dir   tdata                      tuser      items
// req       in    [31:0] seed                [0] mode   draw (mode 0) or seed load (mode 1)
// rsp       out   [30:0] random_value, pad   none       one per draw, none per load
//
// one item at a time; req_tready is high only while the sequencer is idle
// a seed load writes the six seed words in turn and then returns to idle
// a draw runs four products on the shared multiplier, each
// folded back below 2^31 in up to three passes of that same multiplier, then reduced
// a result waiting on rsp holds the next draw's last step until it is taken
// synchronous reset loads the state of seed zero and empties the result register

`default_nettype none

module combined_mrg_random_generator_unit import cmrg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] seed
   input  wire logic        req_tuser,   // [0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [30:0] random_value, [31] zero
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_FOLD = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       term_ff, term_in;
   logic [2:0]       idx_ff, idx_in;
   logic [31:0]      seed_ff, seed_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   word_type         pos_ff, pos_in;
   word_type         first_oldest_ff, first_oldest_in;
   word_type         first_middle_ff, first_middle_in;
   word_type         first_newest_ff, first_newest_in;
   word_type         second_oldest_ff, second_oldest_in;
   word_type         second_middle_ff, second_middle_in;
   word_type         second_newest_ff, second_newest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_data_ff, rsp_data_in;

   logic [19:0]      term_coef;
   word_type         term_x;
   logic [20:0]      fold_k;
   word_type         term_mod;
   logic             fold_step;
   logic [20:0]      mul_a;
   word_type         mul_b;
   logic [51:0]      product;
   logic [ACC_W-1:0] acc_sum;
   logic [19:0]      acc_hi;
   word_type         acc_lo;
   word_type         red;
   logic [31:0]      comb_wide;
   word_type         comb_val;
   logic [31:0]      out_wide;
   word_type         load_word;
   logic             req_fire;

   // operands of the current product term
   always_comb begin
      case (term_ff)
         TERM_ONE_POS: begin
            term_coef = COEF_ONE_POS;
            term_x    = first_middle_ff;
            fold_k    = FOLD_ONE;
            term_mod  = MOD_ONE;
         end
         TERM_ONE_NEG: begin
            term_coef = COEF_ONE_NEG;
            term_x    = first_oldest_ff;
            fold_k    = FOLD_ONE;
            term_mod  = MOD_ONE;
         end
         TERM_TWO_POS: begin
            term_coef = COEF_TWO_POS;
            term_x    = second_newest_ff;
            fold_k    = FOLD_TWO;
            term_mod  = MOD_TWO;
         end
         default: begin
            term_coef = COEF_TWO_NEG;
            term_x    = second_oldest_ff;
            fold_k    = FOLD_TWO;
            term_mod  = MOD_TWO;
         end
      endcase
   end

   // shared multiply-add: coefficient times word, or fold of the high bits times 2^31 mod m
   assign acc_hi    = acc_ff[ACC_W-1:31];
   assign acc_lo    = acc_ff[30:0];
   assign fold_step = (state_ff == ST_FOLD);
   assign mul_a     = fold_step ? fold_k : {1'b0, term_coef};
   assign mul_b     = fold_step ? {11'd0, acc_hi} : term_x;
   assign product   = {31'd0, mul_a} * {21'd0, mul_b};
   assign acc_sum   = product[ACC_W-1:0] + (fold_step ? {20'd0, acc_lo} : {ACC_W{1'b0}});

   // final reduction once the accumulator is below 2^31
   assign red = (acc_lo >= term_mod) ? acc_lo - term_mod : acc_lo;

   // positive term minus negative term, modulo the component's modulus
   assign comb_wide = (pos_ff >= red) ? {1'b0, pos_ff} - {1'b0, red}
                                      : {1'b0, pos_ff} + {1'b0, term_mod} - {1'b0, red};
   assign comb_val  = comb_wide[30:0];

   // output: newest words subtracted modulo m1
   assign out_wide = (first_newest_ff >= second_newest_ff)
                   ? {1'b0, first_newest_ff} - {1'b0, second_newest_ff}
                   : {1'b0, first_newest_ff} + {1'b0, MOD_ONE} - {1'b0, second_newest_ff};

   // one seed word per cycle during a load
   assign load_word = seed_word(seed_key(idx_ff), seed_ff);

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // sequencer
   always_comb begin
      state_in         = state_ff;
      term_in          = term_ff;
      idx_in           = idx_ff;
      seed_in          = seed_ff;
      acc_in           = acc_ff;
      pos_in           = pos_ff;
      first_oldest_in  = first_oldest_ff;
      first_middle_in  = first_middle_ff;
      first_newest_in  = first_newest_ff;
      second_oldest_in = second_oldest_ff;
      second_middle_in = second_middle_ff;
      second_newest_in = second_newest_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  seed_in  = (req_tdata == SEED_ALL_ONES) ? 32'd0 : req_tdata;
                  idx_in   = WORD_FIRST_OLDEST;
                  state_in = ST_LOAD;
               end else begin
                  term_in  = TERM_ONE_POS;
                  state_in = ST_MUL;
               end
            end
         end
         ST_LOAD: begin
            case (idx_ff)
               WORD_FIRST_OLDEST:  first_oldest_in  = load_word;
               WORD_FIRST_MIDDLE:  first_middle_in  = load_word;
               WORD_FIRST_NEWEST:  first_newest_in  = load_word;
               WORD_SECOND_OLDEST: second_oldest_in = load_word;
               WORD_SECOND_MIDDLE: second_middle_in = load_word;
               default:            second_newest_in = load_word;
            endcase
            if (idx_ff == WORD_SECOND_NEWEST) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         ST_MUL: begin
            acc_in   = acc_sum;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (acc_hi != 20'd0) begin
               acc_in = acc_sum;
            end else begin
               case (term_ff) inside
                  TERM_ONE_POS, TERM_TWO_POS: begin
                     pos_in = red;
                  end
                  TERM_ONE_NEG: begin
                     first_oldest_in = first_middle_ff;
                     first_middle_in = first_newest_ff;
                     first_newest_in = comb_val;
                  end
                  default: begin
                     second_oldest_in = second_middle_ff;
                     second_middle_in = second_newest_ff;
                     second_newest_in = comb_val;
                  end
               endcase
               if (term_ff == TERM_TWO_NEG) begin
                  state_in = ST_OUT;
               end else begin
                  term_in  = term_ff + 2'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = out_wide[30:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and state words
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         term_ff          <= TERM_ONE_POS;
         idx_ff           <= WORD_FIRST_OLDEST;
         rsp_valid_ff     <= 1'b0;
         first_oldest_ff  <= seed_word(seed_key(WORD_FIRST_OLDEST), 32'd0);
         first_middle_ff  <= seed_word(seed_key(WORD_FIRST_MIDDLE), 32'd0);
         first_newest_ff  <= seed_word(seed_key(WORD_FIRST_NEWEST), 32'd0);
         second_oldest_ff <= seed_word(seed_key(WORD_SECOND_OLDEST), 32'd0);
         second_middle_ff <= seed_word(seed_key(WORD_SECOND_MIDDLE), 32'd0);
         second_newest_ff <= seed_word(seed_key(WORD_SECOND_NEWEST), 32'd0);
      end else begin
         state_ff         <= state_in;
         term_ff          <= term_in;
         idx_ff           <= idx_in;
         rsp_valid_ff     <= rsp_valid_in;
         first_oldest_ff  <= first_oldest_in;
         first_middle_ff  <= first_middle_in;
         first_newest_ff  <= first_newest_in;
         second_oldest_ff <= second_oldest_in;
         second_middle_ff <= second_middle_in;
         second_newest_ff <= second_newest_in;
      end
   end

   // working data
   always_ff @(posedge clock) begin
      seed_ff     <= seed_in;
      acc_ff      <= acc_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ design/cmrg_checker.sv @@
`default_nettype none

module cmrg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a result is below m1 and its pad bit is zero
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31] == 1'b0 && rsp_tdata[30:0] != 31'h7FFFFFFF)
      else $error("result out of range");

   // the unit is busy right after it takes an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // a seed load produces no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("seed load produced a result");

endmodule

bind combined_mrg_random_generator_unit cmrg_checker u_cmrg_checker (.*);

`default_nettype wire

@@ verif/combined_mrg_random_generator_unit_tb.sv @@
`default_nettype none

module combined_mrg_random_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // item kinds carried on req_tuser
   localparam logic MODE_DRAW = 1'b0;
   localparam logic MODE_SEED = 1'b1;

   // generator constants
   localparam logic [31:0] M1         = 32'd2147483647;
   localparam logic [31:0] M2         = 32'd2145483479;
   localparam logic [31:0] SEED_SPAN  = 32'd2145483478;
   localparam logic [31:0] SEED_ONES  = 32'hFFFFFFFF;
   localparam logic [63:0] A1_POS     = 64'd63308;
   localparam logic [63:0] A1_NEG     = 64'd183326;
   localparam logic [63:0] A2_POS     = 64'd86098;
   localparam logic [63:0] A2_NEG     = 64'd539608;
   localparam logic [31:0] KEY_ONE_OLD = 32'd2039845123;
   localparam logic [31:0] KEY_ONE_MID = 32'd182401045;
   localparam logic [31:0] KEY_ONE_NEW = 32'd1190945568;
   localparam logic [31:0] KEY_TWO_OLD = 32'd943583831;
   localparam logic [31:0] KEY_TWO_MID = 32'd1345908737;
   localparam logic [31:0] KEY_TWO_NEW = 32'd723161013;

   // positions within one component's history
   localparam int OLD = 0;
   localparam int MID = 1;
   localparam int NEW = 2;

   localparam int RANDOM_ITEMS = 1150;
   localparam int IDLE_LIMIT   = 3000;
   localparam int LONG_HOLD    = 600;

   typedef struct {
      logic        mode;
      logic [31:0] seed;
      bit          drain_first;
   } gen_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] seed
   logic        req_tuser = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [30:0] random_value, [31] zero

   gen_req_type req_items[$];
   logic [30:0] expected_values[$];
   logic [30:0] lane_one[3];
   logic [30:0] lane_two[3];
   int          errors = 0;
   int          results_seen = 0;

   combined_mrg_random_generator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // one state word from its key and the seed
   function automatic logic [30:0] seed_to_word(input logic [31:0] key, input logic [31:0] s);
      logic [31:0] v;
      v = (key ^ s) & 32'h7FFFFFFF;
      return 31'((v % SEED_SPAN) + 32'd1);
   endfunction

   task automatic reseed_lanes(input logic [31:0] seed);
      logic [31:0] s;
      s = (seed == SEED_ONES) ? 32'd0 : seed;
      lane_one[OLD] = seed_to_word(KEY_ONE_OLD, s);
      lane_one[MID] = seed_to_word(KEY_ONE_MID, s);
      lane_one[NEW] = seed_to_word(KEY_ONE_NEW, s);
      lane_two[OLD] = seed_to_word(KEY_TWO_OLD, s);
      lane_two[MID] = seed_to_word(KEY_TWO_MID, s);
      lane_two[NEW] = seed_to_word(KEY_TWO_NEW, s);
   endtask

   // (a*x - b*y) mod m, exact
   function automatic logic [31:0] mrg_term(input logic [63:0] a, input logic [30:0] x,
                                            input logic [63:0] b, input logic [30:0] y,
                                            input logic [31:0] m);
      logic [63:0] pos, neg, mm;
      mm  = {32'd0, m};
      pos = (a * {33'd0, x}) % mm;
      neg = (b * {33'd0, y}) % mm;
      return 32'((pos + mm - neg) % mm);
   endfunction

   // advance both components and form the combined value
   task automatic step_lanes(output logic [30:0] value);
      logic [31:0] n1, n2, r;
      n1 = mrg_term(A1_POS, lane_one[MID], A1_NEG, lane_one[OLD], M1);
      lane_one[OLD] = lane_one[MID];
      lane_one[MID] = lane_one[NEW];
      lane_one[NEW] = n1[30:0];
      n2 = mrg_term(A2_POS, lane_two[NEW], A2_NEG, lane_two[OLD], M2);
      lane_two[OLD] = lane_two[MID];
      lane_two[MID] = lane_two[NEW];
      lane_two[NEW] = n2[30:0];
      r = (n1 < n2) ? n1 + (M1 - n2) : n1 - n2;
      value = r[30:0];
   endtask

   function automatic logic [31:0] any_key();
      case ($urandom_range(0, 5))
         0:       return KEY_ONE_OLD;
         1:       return KEY_ONE_MID;
         2:       return KEY_ONE_NEW;
         3:       return KEY_TWO_OLD;
         4:       return KEY_TWO_MID;
         default: return KEY_TWO_NEW;
      endcase
   endfunction

   // seeds biased toward the all-ones substitute and the wrap of the seed range
   function automatic logic [31:0] pick_seed();
      logic [31:0] near;
      near = SEED_SPAN - 32'd1 + 32'($urandom_range(0, 2));
      case ($urandom_range(0, 7))
         0:       return SEED_ONES;
         1:       return any_key() ^ near ^ {$urandom_range(0, 1) == 1, 31'd0};
         2:       return any_key() ^ 32'h7FFFFFFF ^ {$urandom_range(0, 1) == 1, 31'd0};
         3:       return 32'($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   task automatic add_item(input logic mode, input logic [31:0] seed, input bit drain = 0);
      gen_req_type it;
      it.mode = mode;
      it.seed = seed;
      it.drain_first = drain;
      req_items.push_back(it);
   endtask

   // stimulus and end of run
   initial begin
      int n;
      int run;
      lane_one = '{default: '0};
      lane_two = '{default: '0};
      reseed_lanes(32'd0);

      // draws from the reset state, with the ignored seed field at both extremes
      add_item(MODE_DRAW, 32'd0);
      add_item(MODE_DRAW, SEED_ONES);
      add_item(MODE_DRAW, 32'h5A5A5A5A);
      // seed zero and its all-ones substitute give the same sequence
      add_item(MODE_SEED, 32'd0);
      add_item(MODE_DRAW, 32'd0);
      add_item(MODE_DRAW, 32'd0);
      add_item(MODE_SEED, SEED_ONES);
      add_item(MODE_DRAW, 32'd0);
      add_item(MODE_DRAW, 32'hA5A5A5A5);
      add_item(MODE_SEED, 32'hFFFFFFFE);
      add_item(MODE_DRAW, 32'd0);
      // top seed bit is masked off
      add_item(MODE_SEED, 32'h80000000);
      add_item(MODE_DRAW, 32'd0);
      add_item(MODE_SEED, 32'h7FFFFFFF);
      add_item(MODE_DRAW, 32'd0);
      // seed words landing on the wrap of the seed range
      add_item(MODE_SEED, KEY_ONE_OLD ^ SEED_SPAN);
      add_item(MODE_DRAW, 32'd0);
      add_item(MODE_SEED, KEY_TWO_OLD ^ (SEED_SPAN - 32'd1));
      add_item(MODE_DRAW, 32'd0);
      add_item(MODE_SEED, KEY_TWO_NEW ^ 32'hFFFFFFFF);
      add_item(MODE_DRAW, 32'd0);
      add_item(MODE_DRAW, 32'd0);

      // random part: mostly a load followed by a run of draws
      n = 0;
      while (n < RANDOM_ITEMS) begin
         add_item(MODE_SEED, pick_seed(), n == 0 || (n % 400) < 5 && n > 5);
         n++;
         if ($urandom_range(0, 9) == 0) begin
            add_item(MODE_SEED, pick_seed());
            n++;
         end
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 30);
         repeat (run) begin
            add_item(MODE_DRAW, $urandom);
            n++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (req_items.size() != 0 || req_tvalid || expected_values.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_values.size() == 0 && !rsp_tvalid) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // sender: bursts and gaps, optional pause until all results are back
   int burst_left = 8;
   int gap_left = 0;

   always @(posedge clock) begin
      gen_req_type cur;
      logic [30:0] value;
      bit          taken;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         taken = req_tvalid && req_tready;
         if (taken) begin
            cur = req_items.pop_front();
            if (cur.mode == MODE_SEED) begin
               reseed_lanes(cur.seed);
            end else begin
               step_lanes(value);
               expected_values.push_back(value);
            end
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                        : $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end
         end
         if (!req_tvalid || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (req_items.size() != 0 &&
                         !(req_items[0].drain_first && expected_values.size() != 0)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= req_items[0].seed;
               req_tuser  <= req_items[0].mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result, stalls on its own pattern, one long hold
   int  hold_left = 0;
   bit  hold_done = 0;
   int  rx_cycle = 0;
   int  rx_style = 0;

   always @(posedge clock) begin
      logic [30:0] want;
      logic        next_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_values.size() == 0) begin
               errors++;
               $display("%0t unexpected result: expected none, actual %h", $realtime,
                        rsp_tdata[30:0]);
            end else begin
               want = expected_values.pop_front();
               if (rsp_tdata[30:0] !== want) begin
                  errors++;
                  $display("%0t random_value mismatch: expected %h, actual %h", $realtime,
                           want, rsp_tdata[30:0]);
               end
            end
         end
         rx_cycle++;
         if (rx_cycle % 128 == 0)
            rx_style = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (!hold_done && results_seen >= 300) begin
            hold_done = 1;
            hold_left = LONG_HOLD;
            next_ready = 1'b0;
         end else begin
            case (rx_style)
               0:       next_ready = 1'b1;
               1:       next_ready = $urandom_range(0, 1) == 1;
               2:       next_ready = $urandom_range(0, 3) == 0;
               default: next_ready = rx_cycle[2];
            endcase
         end
         rsp_tready <= next_ready;
      end
   end

   // watchdog on cycles without any accepted item
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire

@@ sim.f @@
design/cmrg_pkg.sv
design/combined_mrg_random_generator_unit.sv
design/cmrg_checker.sv
verif/combined_mrg_random_generator_unit_tb.sv
